// ----- rtl/rtc3w_pkg.sv -----
// Shared types for the three-wire RTC serial master.
// Tick and result beat structs, configuration bundle and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package rtc3w_pkg;

  localparam int TimeW = 10;
  localparam int WaitW = 11;

  // command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
  localparam logic [1:0] REG_CE_SETUP    = 2'd1;
  localparam logic [1:0] REG_CE_HOLD     = 2'd2;

  localparam logic [TimeW-1:0] HALF_PERIOD_RESET = 10'd50;
  localparam logic [TimeW-1:0] CE_SETUP_RESET    = 10'd200;
  localparam logic [TimeW-1:0] CE_HOLD_RESET     = 10'd20;

  typedef struct packed {
    logic [1:0] command;
    logic [5:0] reg_addr;
    logic [7:0] write_data;
    logic       io_in;
  } tick_t;

  typedef struct packed {
    logic       ce_pin;
    logic       sclk_pin;
    logic       io_out;
    logic       io_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
  } res_t;

  typedef struct packed {
    logic [TimeW-1:0] half_period_ticks;
    logic [TimeW-1:0] ce_setup_ticks;
    logic [TimeW-1:0] ce_hold_ticks;
  } cfg_t;

  // a programmed zero acts as one
  function automatic logic [TimeW-1:0] at_least_one(input logic [TimeW-1:0] v);
    return (v == '0) ? TimeW'(1) : v;
  endfunction

endpackage

// ----- rtl/three_wire_rtc_serial_master_unit.sv -----
// Top level of the three-wire RTC serial master: handshake and result register.
// Depends on rtc3w_pkg, rtc3w_cfg and rtc3w_seq.
// Result beat: registered, valid in the cycle after its tick beat is accepted.
// Throughput: one tick beat per cycle while a held result does not stall it;
//   sequencer and result register advance in the cycle a beat is accepted.
// Reset (rst, synchronous): sequencer idle, pins low and released, timing
//   registers at 50/200/20 ticks, result register empty.
`timescale 1ns / 1ps

module three_wire_rtc_serial_master_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wen,
  input  logic [1:0]                   cfg_index,
  input  logic [rtc3w_pkg::TimeW-1:0]  cfg_data,
  input  logic                         tick_valid,
  output logic                         tick_stall,
  input  rtc3w_pkg::tick_t             tick_data,
  output logic                         res_valid,
  input  logic                         res_stall,
  output rtc3w_pkg::res_t              res_data
);

  rtc3w_pkg::cfg_t cfg;
  rtc3w_pkg::res_t res_comb;
  logic            accept;

  assign tick_stall = res_valid && res_stall;
  assign accept     = tick_valid && !tick_stall;

  rtc3w_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rtc3w_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .step (accept),
    .tick (tick_data),
    .cfg  (cfg),
    .res  (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_data <= res_comb;
    end
  end

endmodule

// ----- rtl/rtc3w_cfg.sv -----
// Timing configuration registers of the three-wire RTC serial master.
// Depends on rtc3w_pkg.
`timescale 1ns / 1ps

module rtc3w_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wen,
  input  logic [1:0]                   cfg_index,
  input  logic [rtc3w_pkg::TimeW-1:0]  cfg_data,
  output rtc3w_pkg::cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period_ticks <= rtc3w_pkg::HALF_PERIOD_RESET;
      cfg.ce_setup_ticks    <= rtc3w_pkg::CE_SETUP_RESET;
      cfg.ce_hold_ticks     <= rtc3w_pkg::CE_HOLD_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        rtc3w_pkg::REG_HALF_PERIOD: cfg.half_period_ticks <= cfg_data;
        rtc3w_pkg::REG_CE_SETUP:    cfg.ce_setup_ticks    <= cfg_data;
        rtc3w_pkg::REG_CE_HOLD:     cfg.ce_hold_ticks     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/rtc3w_seq.sv -----
// Bus sequencer: phase, wait counter, shift bytes and pin registers.
// Advances one tick per accepted beat and forms that beat's result.
// Depends on rtc3w_pkg.
`timescale 1ns / 1ps

module rtc3w_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  rtc3w_pkg::tick_t   tick,
  input  rtc3w_pkg::cfg_t    cfg,
  output rtc3w_pkg::res_t    res
);

  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_CE_LOW   = 4'd1;
  localparam logic [3:0] PH_CLK_LOW  = 4'd2;
  localparam logic [3:0] PH_SETUP    = 4'd3;
  localparam logic [3:0] PH_CMD_LOW  = 4'd4;
  localparam logic [3:0] PH_CMD_HIGH = 4'd5;
  localparam logic [3:0] PH_RX_TURN  = 4'd6;
  localparam logic [3:0] PH_RX_LOW   = 4'd7;
  localparam logic [3:0] PH_RX_HIGH  = 4'd8;
  localparam logic [3:0] PH_HOLD     = 4'd9;
  localparam logic [3:0] PH_DAT_LOW  = 4'd10;
  localparam logic [3:0] PH_DAT_HIGH = 4'd11;

  localparam int WaitW = rtc3w_pkg::WaitW;

  logic [3:0]       phase, phase_next;
  logic [2:0]       bit_index, bit_index_next;
  logic [WaitW-1:0] wait_count, wait_count_next;
  logic [7:0]       command_byte, command_byte_next;
  logic [7:0]       data_byte, data_byte_next;
  logic             is_write, is_write_next;
  logic [7:0]       received_byte, received_byte_next;
  logic             sclk, sclk_next;
  logic             io_out, io_out_next;
  logic             io_drive, io_drive_next;
  logic             done;

  logic [WaitW-1:0] hp, hp2, setup_w, hold_w;
  logic             start;

  assign hp      = {1'b0, rtc3w_pkg::at_least_one(cfg.half_period_ticks)};
  assign hp2     = {rtc3w_pkg::at_least_one(cfg.half_period_ticks), 1'b0};
  assign setup_w = {1'b0, rtc3w_pkg::at_least_one(cfg.ce_setup_ticks)};
  assign hold_w  = {1'b0, rtc3w_pkg::at_least_one(cfg.ce_hold_ticks)};
  assign start   = (tick.command == rtc3w_pkg::CMD_READ) ||
                   (tick.command == rtc3w_pkg::CMD_WRITE);

  always_comb begin
    phase_next         = phase;
    bit_index_next     = bit_index;
    wait_count_next    = wait_count;
    command_byte_next  = command_byte;
    data_byte_next     = data_byte;
    is_write_next      = is_write;
    received_byte_next = received_byte;
    sclk_next          = sclk;
    io_out_next        = io_out;
    io_drive_next      = io_drive;
    done               = 1'b0;

    if (phase == PH_IDLE || phase > PH_DAT_HIGH) begin
      phase_next = PH_IDLE;
      if (start) begin
        is_write_next     = (tick.command == rtc3w_pkg::CMD_WRITE);
        command_byte_next = {1'b1, tick.reg_addr, ~is_write_next};
        data_byte_next    = is_write_next ? tick.write_data : 8'h00;
        bit_index_next    = 3'd0;
        phase_next        = PH_CE_LOW;
        wait_count_next   = hp;
      end
    end else if (wait_count > WaitW'(1)) begin
      wait_count_next = wait_count - WaitW'(1);
    end else begin
      case (phase)
        PH_CE_LOW: begin
          sclk_next       = 1'b0;
          phase_next      = PH_CLK_LOW;
          wait_count_next = hp;
        end
        PH_CLK_LOW: begin
          phase_next      = PH_SETUP;
          wait_count_next = setup_w;
        end
        PH_SETUP: begin
          bit_index_next  = 3'd0;
          sclk_next       = 1'b0;
          io_drive_next   = 1'b1;
          io_out_next     = command_byte[0];
          phase_next      = PH_CMD_LOW;
          wait_count_next = hp;
        end
        PH_CMD_LOW: begin
          sclk_next       = 1'b1;
          phase_next      = PH_CMD_HIGH;
          wait_count_next = hp;
        end
        PH_CMD_HIGH: begin
          if (bit_index != 3'd7) begin
            bit_index_next  = bit_index + 3'd1;
            sclk_next       = 1'b0;
            io_drive_next   = 1'b1;
            io_out_next     = command_byte[bit_index_next];
            phase_next      = PH_CMD_LOW;
            wait_count_next = hp;
          end else if (is_write) begin
            bit_index_next  = 3'd0;
            sclk_next       = 1'b0;
            io_drive_next   = 1'b1;
            io_out_next     = data_byte[0];
            phase_next      = PH_DAT_LOW;
            wait_count_next = hp;
          end else begin
            // turnaround: release IO, SCLK stays high
            io_drive_next   = 1'b0;
            sclk_next       = 1'b1;
            phase_next      = PH_RX_TURN;
            wait_count_next = hp;
          end
        end
        PH_DAT_LOW: begin
          sclk_next       = 1'b1;
          phase_next      = PH_DAT_HIGH;
          wait_count_next = hp;
        end
        PH_DAT_HIGH: begin
          if (bit_index != 3'd7) begin
            bit_index_next  = bit_index + 3'd1;
            sclk_next       = 1'b0;
            io_drive_next   = 1'b1;
            io_out_next     = data_byte[bit_index_next];
            phase_next      = PH_DAT_LOW;
            wait_count_next = hp;
          end else begin
            bit_index_next  = 3'd0;
            phase_next      = PH_IDLE;
            wait_count_next = '0;
            done            = 1'b1;
          end
        end
        PH_RX_TURN: begin
          bit_index_next  = 3'd0;
          sclk_next       = 1'b0;
          phase_next      = PH_RX_LOW;
          wait_count_next = hp2;
        end
        PH_RX_LOW: begin
          // sample on the tick that raises SCLK
          if (tick.io_in) data_byte_next[bit_index] = 1'b1;
          sclk_next       = 1'b1;
          phase_next      = PH_RX_HIGH;
          wait_count_next = hp;
        end
        PH_RX_HIGH: begin
          if (bit_index != 3'd7) begin
            bit_index_next  = bit_index + 3'd1;
            sclk_next       = 1'b0;
            phase_next      = PH_RX_LOW;
            wait_count_next = hp2;
          end else begin
            bit_index_next  = 3'd0;
            phase_next      = PH_HOLD;
            wait_count_next = hold_w;
          end
        end
        default: begin
          received_byte_next = data_byte;
          phase_next         = PH_IDLE;
          wait_count_next    = '0;
          done               = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_index     <= 3'd0;
      wait_count    <= '0;
      command_byte  <= 8'h00;
      data_byte     <= 8'h00;
      is_write      <= 1'b0;
      received_byte <= 8'h00;
      sclk          <= 1'b0;
      io_out        <= 1'b0;
      io_drive      <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      bit_index     <= bit_index_next;
      wait_count    <= wait_count_next;
      command_byte  <= command_byte_next;
      data_byte     <= data_byte_next;
      is_write      <= is_write_next;
      received_byte <= received_byte_next;
      sclk          <= sclk_next;
      io_out        <= io_out_next;
      io_drive      <= io_drive_next;
    end
  end

  // pin levels after this tick's action
  always_comb begin
    res.ce_pin    = (phase_next >= PH_SETUP && phase_next <= PH_RX_HIGH) ||
                    phase_next == PH_DAT_LOW || phase_next == PH_DAT_HIGH;
    res.sclk_pin  = sclk_next;
    res.io_out    = io_out_next;
    res.io_drive  = io_drive_next;
    res.busy_res  = (phase_next != PH_IDLE);
    res.done_res  = done;
    res.read_data = received_byte_next;
  end

endmodule
